// ===== sv/rtlpm_pkg.sv =====
// Shared types and constants of the longest-prefix route table.
package rtlpm_pkg;

  localparam int unsigned ADDR_W = 32;

  localparam logic [ADDR_W-1:0] MISS_HOP = '1;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_DEL    = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DIRECT    = 3'd3,
    ST_FULL      = 3'd4,
    ST_HIT       = 3'd5
  } status_t;

  typedef struct packed {
    mode_t             mode;
    logic [ADDR_W-1:0] route_prefix;
    logic [ADDR_W-1:0] route_mask;
    logic [ADDR_W-1:0] route_next_hop;
    logic [ADDR_W-1:0] lookup_addr;
  } in_req_t;

  typedef struct packed {
    status_t           status;
    logic              found;
    logic [ADDR_W-1:0] next_hop_out;
  } out_rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] next_hop;
  } route_t;

  typedef struct packed {
    logic exact;
    logic pfx_hit;
    logic mask_ge;
  } cmp_res_t;

endpackage

// ===== sv/rtlpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rtlpm_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/rtlpm_cmp.sv =====
// Shared compare unit: checks one stored route against the pending request.
module rtlpm_cmp (
  input  rtlpm_pkg::route_t            entry,
  input  rtlpm_pkg::route_t            key,
  input  logic [rtlpm_pkg::ADDR_W-1:0] addr,
  input  logic [rtlpm_pkg::ADDR_W-1:0] best_mask,
  output rtlpm_pkg::cmp_res_t          res
);
  import rtlpm_pkg::*;

  // Exact triple match for delete, prefix match and mask rank for lookup.
  assign res.exact   = (entry == key);
  assign res.pfx_hit = ((addr & entry.mask) == entry.prefix);
  assign res.mask_ge = (entry.mask >= best_mask);

endmodule

// ===== sv/route_table_longest_prefix.sv =====
// Top level of the ordered IPv4 route table with longest-prefix lookup.
//
// A request is taken when start is high and busy is low. Every request
// gives exactly one result, shown on out_rsp for a single cycle while
// out_valid is high; the receiver cannot stall it, so it must take the
// result in that cycle. An add, a refused direct delete, an unused mode and
// any delete or lookup on an empty table answer in the cycle after the
// request, and busy stays low, so a new request may follow at once. A lookup
// reads the route RAM one entry per cycle through one shared compare unit
// and busy is high while it scans. A delete scans the same way up to the
// first exact match at place k, then moves each later route up one place,
// one RAM read and write per cycle. The single RAM read port and the
// one-entry scan loop set this pace. Among matching routes the largest mask
// wins, the later route on a tie; a winning next hop of 0 answers with the
// looked-up address itself, and a miss answers all ones with status not
// found.
module route_table_longest_prefix #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rtlpm_pkg::in_req_t  in_req,
  output logic                out_valid,
  output rtlpm_pkg::out_rsp_t out_rsp
);
  import rtlpm_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned RT_W  = $bits(route_t);

  // The sequencer is idle, scanning entries, or closing a gap after delete.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  chk_r, chk_nxt;
  in_req_t           req_r, req_nxt;
  logic              hit_r, hit_nxt;
  logic [ADDR_W-1:0] best_mask_r, best_mask_nxt;
  logic [ADDR_W-1:0] best_hop_r, best_hop_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          out_rsp_r, out_rsp_nxt;

  logic              accept;
  logic              full;
  logic              last;
  logic              shift_last;
  logic [CNT_W:0]    rd_idx;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  route_t            wr_route;
  logic [RT_W-1:0]   rd_data;
  route_t            entry;
  route_t            key;
  cmp_res_t          cmp;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign accept = start && (state_r == S_IDLE);
  assign full   = (count_r == CNT_W'(ENTRIES));

  // The entry on the RAM output is entry chk_r while scanning and entry
  // chk_r + 1 while shifting; reads are issued one place ahead.
  assign last       = ({1'b0, chk_r} + (CNT_W + 1)'(1)) == {1'b0, count_r};
  assign shift_last = ({1'b0, chk_r} + (CNT_W + 1)'(2)) == {1'b0, count_r};

  always_comb begin
    case (state_r)
      S_SCAN:  rd_idx = {1'b0, chk_r} + (CNT_W + 1)'(1);
      S_SHIFT: rd_idx = {1'b0, chk_r} + (CNT_W + 1)'(2);
      default: rd_idx = '0;
    endcase
  end

  // Appends are written straight from the request; shifts copy the next
  // entry down into the current place.
  assign wr_en   = (accept && (in_req.mode == MODE_ADD) && !full) || (state_r == S_SHIFT);
  assign wr_addr = (state_r == S_SHIFT) ? chk_r[IDX_W-1:0] : count_r[IDX_W-1:0];

  always_comb begin
    if (state_r == S_SHIFT) begin
      wr_route = entry;
    end else begin
      wr_route.prefix   = in_req.route_prefix;
      wr_route.mask     = in_req.route_mask;
      wr_route.next_hop = in_req.route_next_hop;
    end
  end

  rtlpm_ram #(
    .WIDTH (RT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_route),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign entry        = route_t'(rd_data);
  assign key.prefix   = req_r.route_prefix;
  assign key.mask     = req_r.route_mask;
  assign key.next_hop = req_r.route_next_hop;

  rtlpm_cmp u_cmp (
    .entry     (entry),
    .key       (key),
    .addr      (req_r.lookup_addr),
    .best_mask (best_mask_r),
    .res       (cmp)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    chk_nxt       = chk_r;
    req_nxt       = req_r;
    hit_nxt       = hit_r;
    best_mask_nxt = best_mask_r;
    best_hop_nxt  = best_hop_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt       = in_req;
          chk_nxt       = '0;
          hit_nxt       = 1'b0;
          best_mask_nxt = '0;
          best_hop_nxt  = MISS_HOP;
          case (in_req.mode)
            MODE_ADD: begin
              out_valid_nxt            = 1'b1;
              out_rsp_nxt.found        = 1'b0;
              out_rsp_nxt.next_hop_out = '0;
              if (full) begin
                out_rsp_nxt.status = ST_FULL;
              end else begin
                out_rsp_nxt.status = ST_ADDED;
                count_nxt          = count_r + CNT_W'(1);
              end
            end
            MODE_DEL: begin
              if (in_req.route_next_hop == '0) begin
                out_valid_nxt            = 1'b1;
                out_rsp_nxt.status       = ST_DIRECT;
                out_rsp_nxt.found        = 1'b0;
                out_rsp_nxt.next_hop_out = '0;
              end else if (count_r == '0) begin
                out_valid_nxt            = 1'b1;
                out_rsp_nxt.status       = ST_NOT_FOUND;
                out_rsp_nxt.found        = 1'b0;
                out_rsp_nxt.next_hop_out = '0;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            MODE_LOOKUP: begin
              if (count_r == '0) begin
                out_valid_nxt            = 1'b1;
                out_rsp_nxt.status       = ST_NOT_FOUND;
                out_rsp_nxt.found        = 1'b0;
                out_rsp_nxt.next_hop_out = MISS_HOP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt            = 1'b1;
              out_rsp_nxt.status       = ST_NOT_FOUND;
              out_rsp_nxt.found        = 1'b0;
              out_rsp_nxt.next_hop_out = MISS_HOP;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (req_r.mode == MODE_LOOKUP) begin
          // Later entries win ties, hence the >= in the compare unit.
          if (cmp.pfx_hit && cmp.mask_ge) begin
            hit_nxt       = 1'b1;
            best_mask_nxt = entry.mask;
            best_hop_nxt  = (entry.next_hop == '0) ? req_r.lookup_addr : entry.next_hop;
          end
          if (last) begin
            state_nxt                = S_IDLE;
            out_valid_nxt            = 1'b1;
            out_rsp_nxt.status       = hit_nxt ? ST_HIT : ST_NOT_FOUND;
            out_rsp_nxt.found        = hit_nxt;
            out_rsp_nxt.next_hop_out = best_hop_nxt;
          end else begin
            chk_nxt = chk_r + CNT_W'(1);
          end
        end else begin
          if (cmp.exact) begin
            if (last) begin
              state_nxt                = S_IDLE;
              count_nxt                = count_r - CNT_W'(1);
              out_valid_nxt            = 1'b1;
              out_rsp_nxt.status       = ST_DELETED;
              out_rsp_nxt.found        = 1'b0;
              out_rsp_nxt.next_hop_out = '0;
            end else begin
              // The read of the next entry is already under way.
              state_nxt = S_SHIFT;
            end
          end else if (last) begin
            state_nxt                = S_IDLE;
            out_valid_nxt            = 1'b1;
            out_rsp_nxt.status       = ST_NOT_FOUND;
            out_rsp_nxt.found        = 1'b0;
            out_rsp_nxt.next_hop_out = '0;
          end else begin
            chk_nxt = chk_r + CNT_W'(1);
          end
        end
      end

      S_SHIFT: begin
        if (shift_last) begin
          state_nxt                = S_IDLE;
          count_nxt                = count_r - CNT_W'(1);
          out_valid_nxt            = 1'b1;
          out_rsp_nxt.status       = ST_DELETED;
          out_rsp_nxt.found        = 1'b0;
          out_rsp_nxt.next_hop_out = '0;
        end else begin
          chk_nxt = chk_r + CNT_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r       <= chk_nxt;
    req_r       <= req_nxt;
    hit_r       <= hit_nxt;
    best_mask_r <= best_mask_nxt;
    best_hop_r  <= best_hop_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

endmodule

// ===== tb/route_table_longest_prefix_tb.sv =====
// Self-checking testbench for the longest-prefix route table: directed and random requests.
module route_table_longest_prefix_tb;
  import rtlpm_pkg::*;

  // Table size used for the block and for the shadow copy of its routes.
  localparam int TABLE_DEPTH = 16;
  // Mode value 3 has no name in the package; the block must answer it as a miss.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Status codes run from ST_ADDED up to ST_HIT; the tally is indexed by them.
  localparam int STATUS_KINDS = 6;
  localparam int RANDOM_REQUESTS = 520;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_req_t  in_req = '0;
  logic     out_valid;
  out_rsp_t out_rsp;

  // Shadow copy of the ordered route table, updated when each request is taken.
  route_t   shadow_routes [TABLE_DEPTH];
  int       shadow_count = 0;

  // Answers still owed by the block, oldest first.
  out_rsp_t expected_answers [$];
  out_rsp_t oldest_answer;

  int       mismatch_count = 0;
  int       request_count = 0;
  int       status_tally [STATUS_KINDS];
  // While set, the sender never pauses between requests.
  bit       steady_flow = 1'b0;

  route_table_longest_prefix #(
    .ENTRIES(TABLE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always #4 clk = ~clk;

  // Works out the answer to one request and applies its effect to the shadow
  // table. Add appends at the end, delete removes the first exact match and
  // moves the later routes up, lookup keeps the last match with the largest
  // mask seen so far, which makes the later route win on a tie.
  function automatic out_rsp_t predict_route_answer(input in_req_t req);
    out_rsp_t          ans;
    route_t            target;
    logic              matched;
    logic [ADDR_W-1:0] best_mask;
    ans.status       = ST_NOT_FOUND;
    ans.found        = 1'b0;
    ans.next_hop_out = MISS_HOP;
    target.prefix    = req.route_prefix;
    target.mask      = req.route_mask;
    target.next_hop  = req.route_next_hop;
    case (req.mode)
      MODE_ADD: begin
        ans.next_hop_out = '0;
        if (shadow_count >= TABLE_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          shadow_routes[shadow_count] = target;
          shadow_count++;
          ans.status = ST_ADDED;
        end
      end
      MODE_DEL: begin
        ans.next_hop_out = '0;
        if (req.route_next_hop == '0) begin
          // A direct route is refused before any search.
          ans.status = ST_DIRECT;
        end else begin
          for (int k = 0; k < shadow_count; k++) begin
            if (shadow_routes[k] == target) begin
              for (int j = k; j + 1 < shadow_count; j++) begin
                shadow_routes[j] = shadow_routes[j + 1];
              end
              shadow_count--;
              ans.status = ST_DELETED;
              break;
            end
          end
        end
      end
      MODE_LOOKUP: begin
        matched   = 1'b0;
        best_mask = '0;
        for (int k = 0; k < shadow_count; k++) begin
          if ((req.lookup_addr & shadow_routes[k].mask) == shadow_routes[k].prefix &&
              shadow_routes[k].mask >= best_mask) begin
            matched   = 1'b1;
            best_mask = shadow_routes[k].mask;
            // A next hop of zero means direct delivery to the address itself.
            ans.next_hop_out = (shadow_routes[k].next_hop == '0) ?
                               req.lookup_addr : shadow_routes[k].next_hop;
          end
        end
        if (matched) begin
          ans.status = ST_HIT;
          ans.found  = 1'b1;
        end
      end
      default: begin
        // The unused mode leaves the table alone and answers like a miss.
      end
    endcase
    status_tally[ans.status]++;
    return ans;
  endfunction

  // Draws a route that is mostly well formed: a contiguous mask and a prefix
  // with no host bits. Some routes reuse the mask of a stored route to force
  // ties, some repeat a stored route exactly, and a few carry an irregular mask
  // or stray host bits. Direct routes cannot be deleted, so only a few of them
  // are allowed in the table at once.
  function automatic route_t random_route();
    route_t      r;
    int unsigned pick;
    int unsigned len;
    int          direct_routes;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(0, 32);
    r.mask = (len == 0) ? '0 : (32'hFFFF_FFFF << (32 - len));
    if (pick < 8) begin
      r.mask = $urandom;
    end else if (pick < 30 && shadow_count > 0) begin
      r.mask = shadow_routes[$urandom_range(0, shadow_count - 1)].mask;
    end
    r.prefix = $urandom & r.mask;
    if (pick >= 96) begin
      r.prefix = $urandom;
    end
    direct_routes = 0;
    for (int k = 0; k < shadow_count; k++) begin
      if (shadow_routes[k].next_hop == '0) direct_routes++;
    end
    if (direct_routes < 3 && $urandom_range(0, 99) < 12) begin
      r.next_hop = '0;
    end else if ($urandom_range(0, 99) < 4) begin
      r.next_hop = '1;
    end else begin
      r.next_hop = $urandom;
    end
    if (pick >= 30 && pick < 36 && shadow_count > 0) begin
      r = shadow_routes[$urandom_range(0, shadow_count - 1)];
    end
    return r;
  endfunction

  // Presents one request and holds it until the block takes it. Fields that
  // the operation does not use are filled with random bits so that every input
  // bit toggles. The request stays on the bus after acceptance; the next call
  // either replaces it in the same step or drops start for a short pause.
  task automatic send_request(input logic [1:0] op,
                              input logic [ADDR_W-1:0] pfx, msk, hop, addr);
    in_req_t req;
    req.mode           = mode_t'(op);
    req.route_prefix   = pfx;
    req.route_mask     = msk;
    req.route_next_hop = hop;
    req.lookup_addr    = addr;
    if (op == MODE_LOOKUP) begin
      req.route_prefix   = $urandom;
      req.route_mask     = $urandom;
      req.route_next_hop = $urandom;
    end else if (op == MODE_ADD || op == MODE_DEL) begin
      req.lookup_addr = $urandom;
    end
    if (!steady_flow && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    // Values read right after the edge are the ones the block sampled.
    do @(posedge clk); while (busy !== 1'b0);
    expected_answers.insert(expected_answers.size(), predict_route_answer(req));
    request_count++;
  endtask

  // Every result must match the oldest answer still owed, field by field.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d found %b hop %h",
                 $time, out_rsp.status, out_rsp.found, out_rsp.next_hop_out);
        mismatch_count++;
      end else begin
        oldest_answer = expected_answers.pop_front();
        if (out_rsp.status !== oldest_answer.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, oldest_answer.status, out_rsp.status);
          mismatch_count++;
        end
        if (out_rsp.found !== oldest_answer.found) begin
          $display("%0t: found expected %b actual %b",
                   $time, oldest_answer.found, out_rsp.found);
          mismatch_count++;
        end
        if (out_rsp.next_hop_out !== oldest_answer.next_hop_out) begin
          $display("%0t: next hop expected %h actual %h",
                   $time, oldest_answer.next_hop_out, out_rsp.next_hop_out);
          mismatch_count++;
        end
      end
    end
  end

  // An empty table: lookup misses, delete finds nothing, a direct delete is
  // refused, and the unused mode with every field set answers as a miss.
  task automatic test_empty_table();
    send_request(MODE_LOOKUP, '0, '0, '0, 32'hFFFF_FFFF);
    send_request(MODE_DEL, 32'h0A00_0000, 32'hFF00_0000, 32'h0000_0001, '0);
    send_request(MODE_DEL, 32'h0A00_0000, 32'hFF00_0000, '0, '0);
    send_request(MODE_UNUSED, '1, '1, '1, '1);
  endtask

  // Longest mask wins, the later route wins a tie, a direct route echoes the
  // address, the default route catches the rest, and a delete closes the gap.
  task automatic test_prefix_priority();
    send_request(MODE_ADD, 32'h0000_0000, 32'h0000_0000, 32'hC0A8_0001, '0);
    send_request(MODE_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0002, '0);
    send_request(MODE_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0000_0000, '0);
    send_request(MODE_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0003, '0);
    send_request(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_request(MODE_LOOKUP, '0, '0, '0, 32'h0A01_0203);
    send_request(MODE_LOOKUP, '0, '0, '0, 32'h0A7F_0000);
    send_request(MODE_LOOKUP, '0, '0, '0, 32'hFFFF_FFFF);
    send_request(MODE_LOOKUP, '0, '0, '0, 32'h0000_0000);
    send_request(MODE_DEL, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0003, '0);
    send_request(MODE_LOOKUP, '0, '0, '0, 32'h0A01_0203);
    send_request(MODE_DEL, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0003, '0);
  endtask

  // Fill the table, add one more to see it refused, then delete the first
  // route so that every later one moves up, and look one of them up.
  task automatic test_table_full();
    route_t r;
    while (shadow_count < TABLE_DEPTH) begin
      r = random_route();
      send_request(MODE_ADD, r.prefix, r.mask, r.next_hop, '0);
    end
    r = random_route();
    send_request(MODE_ADD, r.prefix, r.mask, r.next_hop, '0);
    r = shadow_routes[0];
    send_request(MODE_DEL, r.prefix, r.mask, r.next_hop, '0);
    r = shadow_routes[shadow_count - 1];
    send_request(MODE_LOOKUP, '0, '0, '0, r.prefix | ($urandom & ~r.mask));
  endtask

  // Mostly well-formed traffic against the live table. The mix swings between
  // growing and draining so the table keeps passing through empty and full;
  // deletes usually name a stored route and lookups usually fall inside one.
  task automatic test_random_traffic(input int count);
    route_t      r;
    int unsigned pick;
    int unsigned add_share;
    int unsigned del_share;
    logic [ADDR_W-1:0] addr;
    for (int n = 0; n < count; n++) begin
      steady_flow = (n >= 200 && n < 300);
      add_share   = (((n / 90) % 2) == 0) ? 40 : 12;
      del_share   = (((n / 90) % 2) == 0) ? 12 : 35;
      pick        = $urandom_range(0, 99);
      if (pick < add_share) begin
        r = random_route();
        send_request(MODE_ADD, r.prefix, r.mask, r.next_hop, '0);
      end else if (pick < add_share + del_share) begin
        if (shadow_count > 0 && $urandom_range(0, 99) < 75) begin
          r = shadow_routes[$urandom_range(0, shadow_count - 1)];
        end else begin
          r = random_route();
        end
        if ($urandom_range(0, 99) < 10) r.next_hop = '0;
        send_request(MODE_DEL, r.prefix, r.mask, r.next_hop, '0);
      end else if (pick < 92) begin
        if (shadow_count > 0 && $urandom_range(0, 99) < 70) begin
          r    = shadow_routes[$urandom_range(0, shadow_count - 1)];
          addr = r.prefix | ($urandom & ~r.mask);
        end else if ($urandom_range(0, 99) < 10) begin
          addr = $urandom_range(0, 1) ? '1 : '0;
        end else begin
          addr = $urandom;
        end
        send_request(MODE_LOOKUP, '0, '0, '0, addr);
      end else begin
        // Noise: any mode, the unused one included, with raw field values.
        send_request(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    foreach (status_tally[i]) status_tally[i] = 0;
    foreach (shadow_routes[i]) shadow_routes[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_prefix_priority();
    test_table_full();
    test_random_traffic(RANDOM_REQUESTS);

    start <= 1'b0;
    // A delete or lookup scans the whole table, so allow a full scan and
    // some margin after the last owed answer for any stray result.
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk);

    $display("Sent %0d requests: %0d adds taken, %0d deletes done, %0d not found,",
             request_count, status_tally[ST_ADDED], status_tally[ST_DELETED],
             status_tally[ST_NOT_FOUND]);
    $display("%0d direct deletes refused, %0d adds to a full table, %0d lookup hits.",
             status_tally[ST_DIRECT], status_tally[ST_FULL], status_tally[ST_HIT]);
    if (mismatch_count == 0) begin
      $display("route_table_longest_prefix: match");
    end else begin
      $display("route_table_longest_prefix: mismatch");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run: every request scanning a
  // full table after the longest sender pause.
  initial begin
    #2000000;
    $display("Watchdog expired with %0d answers still owed.", expected_answers.size());
    $display("route_table_longest_prefix: mismatch");
    $finish;
  end

endmodule
